// File: rtl/core/smtc_pkg.sv
// Shared constants, register indexes, switch codes and the fixed tanh breakpoint table
// for the sliding-mode torque controller core. No dependencies.
package smtc_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_SURFACE_SLOPE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SWITCHING_GAIN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REACHING_GAIN       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOUNDARY_RECIPROCAL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INERTIA             = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TORQUE_LIMIT        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BRAKE_TORQUE        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TERMINAL_ENABLE     = 3'd7;

  localparam logic [30:0] RESET_BOUNDARY_RECIPROCAL = 31'd65536;
  localparam logic [30:0] RESET_TORQUE_LIMIT        = 31'd19661;
  localparam logic [30:0] RESET_BRAKE_TORQUE        = 31'd19661;

  localparam logic [1:0] SW_UNKNOWN = 2'd0;
  localparam logic [1:0] SW_UP      = 2'd1;
  localparam logic [1:0] SW_MIDDLE  = 2'd2;
  localparam logic [1:0] SW_DOWN    = 2'd3;

  localparam logic signed [31:0] ANGLE_DEADZONE          = 32'sd0;
  localparam logic signed [31:0] VEL_BAND_LOW            = 32'sd0;
  localparam logic signed [31:0] VEL_BAND_HIGH           = 32'sd0;
  localparam logic [31:0]        TERM_ANGLE_THRESHOLD    = 32'd13107;
  localparam logic [31:0]        TERM_VELOCITY_THRESHOLD = 32'd0;

  localparam logic signed [31:0] BAND_LO =
    (VEL_BAND_LOW > VEL_BAND_HIGH) ? VEL_BAND_HIGH : VEL_BAND_LOW;
  localparam logic signed [31:0] BAND_HI =
    (VEL_BAND_LOW > VEL_BAND_HIGH) ? VEL_BAND_LOW : VEL_BAND_HIGH;

  // Round(2^32 / (2000 * pi)).
  localparam logic signed [20:0] VEL_SCALE = 21'sd683565;

  localparam int TANH_SEGMENTS = 64;
  localparam int TANH_SPAN     = 262144;
  localparam int SEG_W         = TANH_SPAN / TANH_SEGMENTS;
  localparam int SEG_BITS      = $clog2(SEG_W);
  localparam int IDX_BITS      = $clog2(TANH_SEGMENTS);
  localparam int TAB_AW        = $clog2(TANH_SEGMENTS + 1);
  localparam int TAB_W         = 17;
  localparam int TH_W          = 18;

  typedef logic [TAB_W-1:0] tanh_tab_t [0:TANH_SEGMENTS];

  typedef struct packed {
    logic load_front;
    logic load_back;
  } tanh_ctl_t;

  // Unsigned long division, used only while the constant table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Breakpoints of tanh in Q16.16, from a Q30 exponential: a fourth-order series at
  // 1/256 of the argument followed by eight squarings.
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t          tab;
    logic [63:0]        q30;
    logic [63:0]        y;
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        t3;
    logic [63:0]        t4;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    q30 = 64'd1073741824;
    for (int i = 0; i < TANH_SEGMENTS; i++) begin
      y  = 64'(2 * i * SEG_W);
      t  = y << 6;
      t2 = (t * t) >> 30;
      t3 = (t2 * t) >> 30;
      t4 = (t3 * t) >> 30;
      e  = (q30 + (t2 >> 1) + udiv64(t4, 64'd24)) - (t + udiv64(t3, 64'd6));
      for (int r = 0; r < 8; r++) begin
        e = (e * e + (64'd1 << 29)) >> 30;
      end
      if (e > q30) begin
        e = q30;
      end
      den = q30 + e;
      num = ((q30 - e) << 16) + (den >> 1);
      tab[i] = TAB_W'(udiv64(num, den));
    end
    tab[TANH_SEGMENTS] = TAB_W'(65536);
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// File: rtl/core/smtc_sample_if.sv
// Input channel of the torque controller: valid/ready handshake plus one sample.
// No dependencies.
interface smtc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_error;
  logic signed [31:0] measured_velocity;
  logic signed [31:0] velocity_setpoint;
  logic [1:0]         left_switch;
  logic [1:0]         right_switch;
  logic               inputs_invalid;

  modport source (
    output valid, position_error, measured_velocity, velocity_setpoint,
    output left_switch, right_switch, inputs_invalid,
    input  ready
  );
  modport sink (
    input  valid, position_error, measured_velocity, velocity_setpoint,
    input  left_switch, right_switch, inputs_invalid,
    output ready
  );
endinterface

// File: rtl/core/smtc_command_if.sv
// Output channel of the torque controller: valid/ready handshake plus one torque command.
// No dependencies.
interface smtc_command_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque;
  logic               torque_valid;

  modport source (output valid, torque, torque_valid, input ready);
  modport sink (input valid, torque, torque_valid, output ready);
endinterface

// File: rtl/core/sliding_mode_torque_controller_core.sv
// Sliding-mode torque controller with a tanh boundary layer, Q16.16 throughout. The core
// takes one sample per clock while the output side keeps up and returns one torque command
// per sample, in order; each multiply and each round-and-saturate step has its own register
// stage, with the tanh lookup in two more. Each stage loads when it is empty or its successor
// loads, so empty stages fill while the output waits. Settings are written through
// write_enable/write_index/write_data while no transaction is in flight; the core does not
// enforce this. Depends on smtc_pkg, smtc_sample_if, smtc_command_if and smtc_tanh.
module sliding_mode_torque_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [smtc_pkg::REG_IDX_W-1:0]      write_index,
  input  logic [smtc_pkg::DATA_W-1:0]         write_data,
  smtc_sample_if.sink                         sample,
  smtc_command_if.source                      command
);
  import smtc_pkg::*;

  localparam int STAGES = 14;

  typedef struct packed {
    logic off;
    logic force_neg;
    logic force_pos;
  } side_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] rnd16_sat(input logic signed [63:0] p);
    logic signed [64:0] biased;
    logic signed [48:0] q;
    biased = {p[63], p} + 65'sd32768;
    q      = biased[64:16];
    if (q > 49'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (q < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return q[31:0];
    end
  endfunction

  logic signed [31:0] surface_slope;
  logic signed [31:0] switching_gain;
  logic signed [31:0] reaching_gain;
  logic [30:0]        boundary_reciprocal;
  logic signed [31:0] inertia;
  logic [30:0]        torque_clamp;
  logic [30:0]        brake_torque;
  logic               terminal_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_slope       <= '0;
      switching_gain      <= '0;
      reaching_gain       <= '0;
      boundary_reciprocal <= RESET_BOUNDARY_RECIPROCAL;
      inertia             <= '0;
      torque_clamp        <= RESET_TORQUE_LIMIT;
      brake_torque        <= RESET_BRAKE_TORQUE;
      terminal_enable     <= 1'b1;
    end else if (write_enable) begin
      case (write_index)
        REG_SURFACE_SLOPE:       surface_slope       <= write_data;
        REG_SWITCHING_GAIN:      switching_gain      <= write_data;
        REG_REACHING_GAIN:       reaching_gain       <= write_data;
        REG_BOUNDARY_RECIPROCAL: boundary_reciprocal <= write_data[30:0];
        REG_INERTIA:             inertia             <= write_data;
        REG_TORQUE_LIMIT:        torque_clamp        <= write_data[30:0];
        REG_BRAKE_TORQUE:        brake_torque        <= write_data[30:0];
        REG_TERMINAL_ENABLE:     terminal_enable     <= write_data[0];
        default: ;
      endcase
    end
  end

  // Stage valids and load enables; a stage loads when it is empty or its successor loads.
  logic [STAGES:1] vld;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !vld[STAGES] || command.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= sample.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign sample.ready = en[1];

  // Stage 1: velocity difference, angle dead zone, output gating and terminal region.
  logic signed [31:0] a_in;
  logic signed [31:0] mv_in;
  logic signed [31:0] tv_in;
  logic [32:0]        a_neg;
  logic [32:0]        tv_neg;
  logic [31:0]        a_abs;
  logic [31:0]        tv_abs;
  logic signed [31:0] adz_next;
  logic               region;
  logic               brake_on;
  side_t              side_next;

  always_comb begin
    a_in   = sample.position_error;
    mv_in  = sample.measured_velocity;
    tv_in  = sample.velocity_setpoint;
    a_neg  = -{a_in[31], a_in};
    tv_neg = -{tv_in[31], tv_in};
    a_abs  = a_in[31] ? a_neg[31:0] : a_in;
    tv_abs = tv_in[31] ? tv_neg[31:0] : tv_in;
    if (a_in > ANGLE_DEADZONE) begin
      adz_next = a_in - ANGLE_DEADZONE;
    end else if (a_in < -ANGLE_DEADZONE) begin
      adz_next = a_in + ANGLE_DEADZONE;
    end else begin
      adz_next = '0;
    end
    region   = (a_abs <= TERM_ANGLE_THRESHOLD) || (tv_abs <= TERM_VELOCITY_THRESHOLD);
    brake_on = terminal_enable && !sample.inputs_invalid && region;
    side_next.off = ((sample.left_switch == SW_DOWN) && (sample.right_switch == SW_DOWN)) ||
                    ((sample.left_switch == SW_UNKNOWN) && (sample.right_switch == SW_UNKNOWN));
    side_next.force_neg = brake_on && (mv_in > BAND_HI);
    side_next.force_pos = brake_on && !(mv_in > BAND_HI) && (mv_in < BAND_LO);
  end

  side_t side [1:STAGES-1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1] <= side_next;
    end
    for (int k = 2; k <= STAGES - 1; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  logic signed [32:0] dv1;
  logic signed [31:0] adz1;
  logic signed [53:0] pv2;
  logic signed [63:0] pca2;
  logic signed [54:0] pv_biased;
  logic signed [31:0] ve3;
  logic signed [31:0] ca3;
  logic signed [31:0] ve4;
  logic signed [31:0] s4;
  logic signed [63:0] p1_5;
  logic signed [63:0] px5;
  logic signed [63:0] p3_5;
  logic signed [31:0] t1_6;
  logic signed [31:0] x6;
  logic signed [31:0] t3_6;
  logic signed [32:0] t13_7;
  logic signed [32:0] t13_8;
  logic signed [TH_W-1:0] th8;
  logic signed [TH_W+31:0] pe9;
  logic signed [32:0] t13_9;
  logic signed [31:0] t2_10;
  logic signed [32:0] t13_10;
  logic signed [31:0] sum11;
  logic signed [63:0] pj12;
  logic signed [31:0] tq13;
  logic signed [31:0] torque;
  logic               torque_valid;

  assign pv_biased = {pv2[53], pv2} + 55'sd2147483648;

  // Stage 13 and the output stage: torque sign flip, clamps and terminal braking.
  logic signed [64:0] pj_biased;
  logic signed [48:0] rj;
  logic signed [48:0] lim49;
  logic signed [31:0] lim32;
  logic signed [31:0] brake32;
  logic signed [31:0] tq_next;
  logic signed [31:0] tb;
  logic signed [31:0] tq_final;

  always_comb begin
    pj_biased = {pj12[63], pj12} + 65'sd32768;
    rj        = pj_biased[64:16];
    lim49     = $signed({18'd0, torque_clamp});
    lim32     = $signed({1'b0, torque_clamp});
    brake32   = $signed({1'b0, brake_torque});
    if (rj < -lim49) begin
      tq_next = lim32;
    end else if (rj > lim49) begin
      tq_next = -lim32;
    end else begin
      tq_next = -rj[31:0];
    end
    tb = tq13;
    if (side[13].force_neg) begin
      if (tq13 > -brake32) begin
        tb = -brake32;
      end
    end else if (side[13].force_pos) begin
      if (tq13 < brake32) begin
        tb = brake32;
      end
    end
    if (tb > lim32) begin
      tq_final = lim32;
    end else if (tb < -lim32) begin
      tq_final = -lim32;
    end else begin
      tq_final = tb;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dv1  <= {mv_in[31], mv_in} - {tv_in[31], tv_in};
      adz1 <= adz_next;
    end
    if (en[2]) begin
      pv2  <= dv1 * VEL_SCALE;
      pca2 <= surface_slope * adz1;
    end
    if (en[3]) begin
      ve3 <= {{9{pv_biased[54]}}, pv_biased[54:32]};
      ca3 <= rnd16_sat(pca2);
    end
    if (en[4]) begin
      ve4 <= ve3;
      s4  <= sat34({{2{ve3[31]}}, ve3} - {{2{ca3[31]}}, ca3});
    end
    if (en[5]) begin
      p1_5 <= surface_slope * ve4;
      px5  <= s4 * $signed({1'b0, boundary_reciprocal});
      p3_5 <= reaching_gain * s4;
    end
    if (en[6]) begin
      t1_6 <= rnd16_sat(p1_5);
      x6   <= rnd16_sat(px5);
      t3_6 <= rnd16_sat(p3_5);
    end
    if (en[7]) begin
      t13_7 <= {t1_6[31], t1_6} + {t3_6[31], t3_6};
    end
    if (en[8]) begin
      t13_8 <= t13_7;
    end
    if (en[9]) begin
      pe9   <= switching_gain * th8;
      t13_9 <= t13_8;
    end
    if (en[10]) begin
      t2_10  <= rnd16_sat({{14{pe9[TH_W+31]}}, pe9});
      t13_10 <= t13_9;
    end
    if (en[11]) begin
      sum11 <= sat34({t13_10[32], t13_10} + {{2{t2_10[31]}}, t2_10});
    end
    if (en[12]) begin
      pj12 <= inertia * sum11;
    end
    if (en[13]) begin
      tq13 <= tq_next;
    end
    if (en[14]) begin
      torque       <= side[13].off ? 32'sd0 : tq_final;
      torque_valid <= !side[13].off;
    end
  end

  tanh_ctl_t tanh_ctl;

  assign tanh_ctl.load_front = en[7];
  assign tanh_ctl.load_back  = en[8];

  smtc_tanh u_tanh (
    .clk (clk),
    .ctl (tanh_ctl),
    .x   (x6),
    .th  (th8)
  );

  assign command.valid        = vld[STAGES];
  assign command.torque       = torque;
  assign command.torque_valid = torque_valid;

endmodule

// File: rtl/core/smtc_tanh.sv
// Two-stage piecewise-linear tanh in Q16.16 with saturation at +/-1.
// Depends on smtc_pkg for the breakpoint table and the stage load controls.
module smtc_tanh (
  input  logic                       clk,
  input  smtc_pkg::tanh_ctl_t        ctl,
  input  logic signed [31:0]         x,
  output logic signed [smtc_pkg::TH_W-1:0] th
);
  import smtc_pkg::*;

  localparam logic signed [30:0] TRUNC_BIAS = 31'(SEG_W - 1);

  logic [32:0]              x_neg;
  logic [31:0]              ax;
  logic [IDX_BITS-1:0]      seg;
  logic [TAB_AW-1:0]        lo_idx;
  logic [TAB_AW-1:0]        hi_idx;
  logic [TAB_W-1:0]         lo_val;
  logic [TAB_W-1:0]         hi_val;

  logic                     neg;
  logic                     over;
  logic [TAB_W-1:0]         lo;
  logic signed [TH_W-1:0]   diff;
  logic [SEG_BITS-1:0]      frac;

  logic signed [30:0]       prod;
  logic signed [30:0]       step;
  logic signed [TH_W-1:0]   mag;

  always_comb begin
    x_neg  = -{x[31], x};
    ax     = x[31] ? x_neg[31:0] : x;
    seg    = ax[SEG_BITS+IDX_BITS-1:SEG_BITS];
    lo_idx = TAB_AW'(seg);
    hi_idx = lo_idx + TAB_AW'(1);
    lo_val = TANH_TAB[lo_idx];
    hi_val = TANH_TAB[hi_idx];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_front) begin
      neg  <= x[31];
      over <= (ax >= 32'(TANH_SPAN));
      lo   <= lo_val;
      diff <= $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});
      frac <= ax[SEG_BITS-1:0];
    end
  end

  always_comb begin
    prod = diff * $signed({1'b0, frac});
    if (prod[30]) begin
      step = (prod + TRUNC_BIAS) >>> SEG_BITS;
    end else begin
      step = prod >>> SEG_BITS;
    end
    if (over) begin
      mag = TH_W'(65536);
    end else begin
      mag = $signed({1'b0, lo}) + step[TH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_back) begin
      th <= neg ? -mag : mag;
    end
  end

endmodule
